// File: hw/rtl/gbs_pkg.sv
// Package for the greedy box suppression block.
// Holds the item structs, the stored box type and the fixed field widths.
// Used by gbs_cell, gbs_iou_unit and greedy_box_suppression_top.
package gbs_pkg;

  localparam int CoordW = 16;
  localparam int SizeW  = 15;
  localparam int AreaW  = 30;
  localparam int ThrW   = 16;
  localparam int IndexW = 10;

  localparam logic [ThrW-1:0] ThresholdReset = 16'd29491;
  localparam int              IndexLimitMax  = 1023;

  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_height;
    logic                     last_box;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] box_index;
    logic              keep;
    logic              store_overflow;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
    logic [AreaW-1:0]         area;
  } kept_box_t;

  typedef struct packed {
    logic      valid;
    kept_box_t kept;
  } cmp_req_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } cmp_res_t;

endpackage

// File: hw/rtl/greedy_box_suppression_top.sv
// Greedy box suppression: an accepted item has its area computed, runs a comparison pass, waits
// for the overlap pipeline to drain and then waits out any output stall before its result is
// registered; the block then returns to idle and can take the next item.
// The kept boxes rotate once through a ring of MAX_KEPT cells past the overlap unit, one
// kept box per cycle, and the block takes no new item until its current item is done.
// Reset clears the kept count, set position and result register and loads the threshold.
module greedy_box_suppression_top #(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_BOXES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  gbs_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output gbs_pkg::out_item_t       out_item_o,
  input  logic                     cfg_wr_en_i,
  input  logic [gbs_pkg::ThrW-1:0] cfg_wr_data_i
);

  localparam int CntW     = $clog2(MAX_KEPT + 1);
  localparam int PosLimit = (MAX_BOXES - 1 < gbs_pkg::IndexLimitMax) ?
                            (MAX_BOXES - 1) : gbs_pkg::IndexLimitMax;

  typedef enum logic [2:0] {
    StIdle,
    StArea,
    StRun,
    StDrain,
    StFinish
  } state_e;

  state_e                        state_q;
  gbs_pkg::in_item_t             cur_q;
  logic [gbs_pkg::AreaW-1:0]     cur_area_q;
  logic [CntW-1:0]               run_cnt_q, kept_count_q;
  logic [gbs_pkg::IndexW-1:0]    set_pos_q;
  logic [gbs_pkg::ThrW-1:0]      thr_q;
  logic                          supp_q;
  logic                          out_valid_q;
  gbs_pkg::out_item_t            out_item_q;

  gbs_pkg::kept_box_t            cur_box;
  gbs_pkg::kept_box_t            ring [MAX_KEPT];
  gbs_pkg::cmp_req_t             req;
  gbs_pkg::cmp_res_t             res;
  logic                          busy;
  logic                          fire, keep, store;

  assign cur_box.left   = cur_q.box_left;
  assign cur_box.top    = cur_q.box_top;
  assign cur_box.width  = cur_q.box_width;
  assign cur_box.height = cur_q.box_height;
  assign cur_box.area   = cur_area_q;

  assign fire  = (state_q == StFinish) && (!out_valid_q || !out_stall_i);
  assign keep  = !supp_q;
  assign store = keep && (kept_count_q < CntW'(MAX_KEPT));

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_ring
    gbs_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(state_q == StRun),
      .load_i (fire && store && (kept_count_q == CntW'(i))),
      .next_i (ring[(i + 1) % MAX_KEPT]),
      .new_i  (cur_box),
      .box_o  (ring[i])
    );
  end

  assign req.valid = (state_q == StRun) && (run_cnt_q < kept_count_q);
  assign req.kept  = ring[0];

  gbs_iou_unit u_iou (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .cur_i (cur_box),
    .thr_i (thr_q),
    .res_o (res),
    .busy_o(busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cur_q        <= '0;
      cur_area_q   <= '0;
      run_cnt_q    <= '0;
      kept_count_q <= '0;
      set_pos_q    <= '0;
      thr_q        <= gbs_pkg::ThresholdReset;
      supp_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      if (res.valid && res.hit) begin
        supp_q <= 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cur_q   <= in_item_i;
            state_q <= StArea;
          end
        end
        StArea: begin
          cur_area_q <= gbs_pkg::AreaW'(cur_q.box_width) * gbs_pkg::AreaW'(cur_q.box_height);
          run_cnt_q  <= '0;
          supp_q     <= 1'b0;
          state_q    <= StRun;
        end
        StRun: begin
          run_cnt_q <= run_cnt_q + CntW'(1);
          if (run_cnt_q == CntW'(MAX_KEPT - 1)) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!busy) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (fire) begin
            out_item_q.box_index      <= set_pos_q;
            out_item_q.keep           <= keep;
            out_item_q.store_overflow <= keep && !store;
            out_item_q.last_result    <= cur_q.last_box;
            if (cur_q.last_box) begin
              kept_count_q <= '0;
              set_pos_q    <= '0;
            end else begin
              kept_count_q <= kept_count_q + CntW'(store);
              if (set_pos_q < gbs_pkg::IndexW'(PosLimit)) begin
                set_pos_q <= set_pos_q + gbs_pkg::IndexW'(1);
              end
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block accepted an item without leaving idle.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_count_q <= CntW'(MAX_KEPT))
    else $error("Kept count exceeds the store depth.");

  a_overflow_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.store_overflow && !out_item_o.keep))
    else $error("Overflow reported for a suppressed item.");

  a_result_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == StRun || state_q == StDrain))
    else $error("Overlap result arrived outside of a comparison pass.");

endmodule

// File: hw/rtl/gbs_cell.sv
// One storage cell of the rotating ring of kept boxes.
// Loads a new box or takes its neighbor's box; depends on gbs_pkg.
module gbs_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic              load_i,
  input  gbs_pkg::kept_box_t next_i,
  input  gbs_pkg::kept_box_t new_i,
  output gbs_pkg::kept_box_t box_o
);

  gbs_pkg::kept_box_t box_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      box_q <= new_i;
    end else if (shift_i) begin
      box_q <= next_i;
    end
  end

  assign box_o = box_q;

endmodule

// File: hw/rtl/gbs_iou_unit.sv
// Pipelined overlap test of the current box against one kept box per cycle.
// Computes inter * 65536 > threshold * union in four stages; depends on gbs_pkg.
module gbs_iou_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gbs_pkg::cmp_req_t            req_i,
  input  gbs_pkg::kept_box_t           cur_i,
  input  logic [gbs_pkg::ThrW-1:0]     thr_i,
  output gbs_pkg::cmp_res_t            res_o,
  output logic                         busy_o
);

  localparam int SumW  = gbs_pkg::AreaW + 1;
  localparam int ProdW = gbs_pkg::ThrW + SumW;

  logic signed [16:0] cur_x1, cur_y1, kept_x1, kept_y1, min_x1, min_y1;
  logic signed [15:0] max_x0, max_y0;
  logic signed [17:0] dx, dy;
  logic               ov;

  logic                        s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [gbs_pkg::SizeW-1:0]   s1_dx_q, s1_dy_q;
  logic                        s1_ov_q;
  logic [SumW-1:0]             s1_asum_q, s2_asum_q, s3_uni_q;
  logic [gbs_pkg::AreaW-1:0]   s2_inter_q, s3_inter_q, s4_inter_q;
  logic [ProdW-1:0]            s4_prod_q;
  logic [ProdW-1:0]            lhs;

  always_comb begin
    cur_x1  = 17'(cur_i.left) + $signed({2'b00, cur_i.width});
    cur_y1  = 17'(cur_i.top) + $signed({2'b00, cur_i.height});
    kept_x1 = 17'(req_i.kept.left) + $signed({2'b00, req_i.kept.width});
    kept_y1 = 17'(req_i.kept.top) + $signed({2'b00, req_i.kept.height});
    min_x1  = (cur_x1 < kept_x1) ? cur_x1 : kept_x1;
    min_y1  = (cur_y1 < kept_y1) ? cur_y1 : kept_y1;
    max_x0  = (cur_i.left > req_i.kept.left) ? cur_i.left : req_i.kept.left;
    max_y0  = (cur_i.top > req_i.kept.top) ? cur_i.top : req_i.kept.top;
    dx      = 18'(min_x1) - 18'(max_x0);
    dy      = 18'(min_y1) - 18'(max_y0);
    ov      = (dx > 18'sd0) && (dy > 18'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q    <= dx[gbs_pkg::SizeW-1:0];
    s1_dy_q    <= dy[gbs_pkg::SizeW-1:0];
    s1_ov_q    <= ov;
    s1_asum_q  <= SumW'(cur_i.area) + SumW'(req_i.kept.area);
    s2_inter_q <= s1_ov_q ? gbs_pkg::AreaW'(s1_dx_q) * gbs_pkg::AreaW'(s1_dy_q) : '0;
    s2_asum_q  <= s1_asum_q;
    s3_uni_q   <= s2_asum_q - SumW'(s2_inter_q);
    s3_inter_q <= s2_inter_q;
    s4_prod_q  <= ProdW'(thr_i) * ProdW'(s3_uni_q);
    s4_inter_q <= s3_inter_q;
  end

  assign lhs = ProdW'({s4_inter_q, 16'h0000});

  assign res_o.valid = s4_valid_q;
  assign res_o.hit   = s4_valid_q && (lhs > s4_prod_q);
  assign busy_o      = s1_valid_q || s2_valid_q || s3_valid_q || s4_valid_q;

endmodule
